@@ hdl/bcat_pkg.sv @@
package bcat_pkg;

  localparam int unsigned BLOCK_COUNT = 1024;
  localparam int unsigned IDX_W       = $clog2(BLOCK_COUNT);
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [WORD_W-1:0] BLOCK_LIMIT = WORD_W'(BLOCK_COUNT);
  localparam logic [WORD_W-1:0] FREE_RESET  = WORD_W'(BLOCK_COUNT - 1);
  localparam logic [WORD_W-1:0] LINK_FREE   = 16'h0000;
  localparam logic [WORD_W-1:0] LINK_END    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] idx;
    logic [WORD_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] free_blocks;
    logic [WORD_W-1:0] link_out;
    logic [WORD_W-1:0] allocated_block;
  } res_t;

endpackage

@@ hdl/block_chain_allocation_table.sv @@
// Set writes the entry; read goes through the registered table read. Allocate takes the
//   first free block, then scans on for the next free entry (or off the table). Free walks
//   the chain clearing links until it ends or meets a free entry or a bad index. A full
//   allocate, block zero or a bad index skips to the reply. One command at a time.
// Reset: a clearing pass over all BLOCK_COUNT (1024) entries rewrites the table; no beat is
//   taken until it ends. Replies pass an output register, which empties at reset.
module block_chain_allocation_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // block_index, link_value
  input  logic [31:0]                       s_axis_tdata,
  // command
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // allocated_block, link_out, free_blocks, status, zero pad
  output logic [bcat_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import bcat_pkg::*;

  cmd_t cmd;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic res_ready;
  logic out_valid;

  assign cmd.op  = op_t'(s_axis_tuser);
  assign cmd.idx = s_axis_tdata[15:0];
  assign cmd.val = s_axis_tdata[31:16];

  bcat_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res.status, out_res.free_blocks,
                          out_res.link_out, out_res.allocated_block};

endmodule

@@ hdl/bcat_core.sv @@
module bcat_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bcat_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output bcat_pkg::res_t res
);
  import bcat_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_READ     = 8'b0000_0100,
    S_SCAN_RD  = 8'b0000_1000,
    S_SCAN_CHK = 8'b0001_0000,
    S_FREE_RD  = 8'b0010_0000,
    S_FREE_CHK = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr;
  logic [WORD_W-1:0] first_free;
  logic [WORD_W-1:0] free_count;
  logic [WORD_W-1:0] pos;
  logic [WORD_W-1:0] steps;
  op_t               op_r;
  logic [WORD_W-1:0] res_alloc;
  logic [WORD_W-1:0] res_link;
  status_t           res_status;

  logic [WORD_W-1:0] mem [BLOCK_COUNT];
  logic [WORD_W-1:0] rd_data;
  logic              we;
  logic              re;
  logic [IDX_W-1:0]  wa;
  logic [IDX_W-1:0]  ra;
  logic [WORD_W-1:0] wd;

  logic start;
  logic in_range;
  logic full;
  logic pos_ok;
  logic free_go;

  assign cmd_ready = (state == S_IDLE);
  assign start     = cmd_valid && cmd_ready;
  assign in_range  = cmd.idx < BLOCK_LIMIT;
  assign full      = (free_count == '0) || (first_free >= BLOCK_LIMIT);
  assign pos_ok    = pos < BLOCK_LIMIT;
  assign free_go   = (steps != BLOCK_LIMIT) && (pos != LINK_END) && pos_ok;

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = pos[IDX_W-1:0];
    ra = pos[IDX_W-1:0];
    wd = LINK_FREE;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr;
        wd = (clr == '0) ? LINK_END : LINK_FREE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ALLOC: begin
              we = !full;
              wa = first_free[IDX_W-1:0];
              wd = LINK_END;
            end
            OP_SET: begin
              we = in_range;
              wa = cmd.idx[IDX_W-1:0];
              wd = cmd.val;
            end
            OP_READ: begin
              re = in_range;
              ra = cmd.idx[IDX_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD:  re = pos_ok;
      S_FREE_RD:  re = free_go;
      S_FREE_CHK: we = (rd_data != LINK_FREE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      first_free <= 16'd1;
      free_count <= FREE_RESET;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IDX_W'(BLOCK_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r       <= cmd.op;
            res_alloc  <= '0;
            res_link   <= '0;
            res_status <= ST_OK;
            state      <= S_DONE;
            case (cmd.op)
              OP_ALLOC: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_alloc  <= first_free;
                  free_count <= free_count - 1'b1;
                  pos        <= first_free + 1'b1;
                  state      <= S_SCAN_RD;
                end
              end
              OP_FREE: begin
                if (!in_range) begin
                  res_status <= ST_RANGE;
                end else if (cmd.idx != '0) begin
                  pos   <= cmd.idx;
                  steps <= '0;
                  state <= S_FREE_RD;
                end
              end
              OP_SET: begin
                if (!in_range) begin
                  res_status <= ST_RANGE;
                end
              end
              default: begin
                if (!in_range) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_link <= rd_data;
          state    <= S_DONE;
        end
        S_SCAN_RD: begin
          if (pos_ok) begin
            state <= S_SCAN_CHK;
          end else begin
            first_free <= pos;
            state      <= S_DONE;
          end
        end
        S_SCAN_CHK: begin
          if (rd_data == LINK_FREE) begin
            first_free <= pos;
            state      <= S_DONE;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_FREE_RD: begin
          if (free_go) begin
            state <= S_FREE_CHK;
          end else begin
            if ((steps != BLOCK_LIMIT) && (pos != LINK_END)) begin
              res_status <= ST_RANGE;
            end
            state <= S_DONE;
          end
        end
        S_FREE_CHK: begin
          if (rd_data == LINK_FREE) begin
            state <= S_DONE;
          end else begin
            if (free_count < BLOCK_LIMIT) begin
              free_count <= free_count + 1'b1;
            end
            if (pos < first_free) begin
              first_free <= pos;
            end
            pos   <= rd_data;
            steps <= steps + 1'b1;
            state <= S_FREE_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign res_valid           = (state == S_DONE);
  assign res.allocated_block = res_alloc;
  assign res.link_out        = res_link;
  assign res.free_blocks     = free_count;
  assign res.status          = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= BLOCK_LIMIT)
    else $error("free count above block count");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(we && re && (wa == ra)))
    else $error("read and write to one entry in one cycle");

  a_full_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status == ST_FULL)) |-> (op_r == OP_ALLOC))
    else $error("full status on a command other than allocate");

  a_alloc_in_table: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (op_r == OP_ALLOC) && (res_status == ST_OK)) |->
      (res_alloc < BLOCK_LIMIT))
    else $error("allocated block outside the table");

  a_alloc_takes_one: assert property (@(posedge clk) disable iff (rst)
    (start && (cmd.op == OP_ALLOC) && !full) |=>
      (free_count == $past(free_count) - 1'b1))
    else $error("allocate did not take one block");

endmodule

@@ sim/allocation_table_checker.sv @@
`timescale 1ns / 100ps

module allocation_table_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bcat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                              mismatches,
  output int                              outstanding,
  output int                              replies,
  output int                              full_replies,
  output int                              range_replies
);
  import bcat_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] alloc_blk;
    logic [WORD_W-1:0] link;
    logic [WORD_W-1:0] free_cnt;
    status_t           status;
  } reply_t;

  logic [WORD_W-1:0] chain_links [BLOCK_COUNT];
  int unsigned       lowest_free;
  int unsigned       free_total;
  reply_t            expected_replies [$];
  int                fails;
  int                seen;
  int                n_full;
  int                n_range;

  function automatic void reset_table();
    for (int i = 0; i < BLOCK_COUNT; i++) chain_links[i] = LINK_FREE;
    chain_links[0] = LINK_END;
    lowest_free = 1;
    free_total  = BLOCK_COUNT - 1;
  endfunction

  function automatic status_t allocate_block(output logic [WORD_W-1:0] blk);
    int unsigned scan;
    blk = '0;
    if (free_total == 0 || lowest_free >= BLOCK_COUNT) return ST_FULL;
    blk = lowest_free[WORD_W-1:0];
    chain_links[lowest_free] = LINK_END;
    scan = lowest_free + 1;
    while (scan < BLOCK_COUNT && chain_links[scan] != LINK_FREE) scan++;
    lowest_free = scan;
    free_total--;
    return ST_OK;
  endfunction

  function automatic status_t free_chain(int unsigned start);
    int unsigned pos;
    int unsigned nxt;
    int unsigned steps;
    pos   = start;
    steps = 0;
    if (pos == 0) return ST_OK;
    while (steps < BLOCK_COUNT) begin
      if (pos == LINK_END || pos == LINK_FREE) return ST_OK;
      if (pos >= BLOCK_COUNT) return ST_RANGE;
      nxt = chain_links[pos];
      if (nxt == LINK_FREE) return ST_OK;
      chain_links[pos] = LINK_FREE;
      if (free_total < BLOCK_COUNT) free_total++;
      if (pos < lowest_free) lowest_free = pos;
      pos = nxt;
      steps++;
    end
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(op_t op, logic [WORD_W-1:0] idx,
                                           logic [WORD_W-1:0] val);
    reply_t r;
    r.alloc_blk = '0;
    r.link      = '0;
    r.status    = ST_OK;
    case (op)
      OP_ALLOC: r.status = allocate_block(r.alloc_blk);
      OP_FREE: begin
        if (idx >= BLOCK_LIMIT) r.status = ST_RANGE;
        else r.status = free_chain(idx);
      end
      OP_SET: begin
        if (idx >= BLOCK_LIMIT) r.status = ST_RANGE;
        else chain_links[idx] = val;
      end
      default: begin
        if (idx >= BLOCK_LIMIT) r.status = ST_RANGE;
        else r.link = chain_links[idx];
      end
    endcase
    r.free_cnt = free_total[WORD_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 40)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      reset_table();
      expected_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (expected_replies.size() == 0) begin
          fails++;
          if (fails <= 40)
            $display("%0t: reply beat with none outstanding, expected nothing, got %h",
                     $time, m_axis_tdata);
        end else begin
          want = expected_replies.pop_front();
          check_field("allocated_block", want.alloc_blk, m_axis_tdata[15:0]);
          check_field("link_out", want.link, m_axis_tdata[31:16]);
          check_field("free_blocks", want.free_cnt, m_axis_tdata[47:32]);
          check_field("status", 16'(want.status), 16'(m_axis_tdata[49:48]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_reply(op_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
        expected_replies.push_back(want);
      end
    end
    mismatches    <= fails;
    outstanding   <= expected_replies.size();
    replies       <= seen;
    full_replies  <= n_full;
    range_replies <= n_range;
  end

endmodule

@@ sim/block_chain_allocation_table_test.sv @@
`timescale 1ns / 100ps

module block_chain_allocation_table_test;
  import bcat_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_CMDS = 690;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // block_index, link_value
  logic [1:0]            s_axis_tuser;   // command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // allocated_block, link_out, free_blocks, status, pad

  int   mismatches;
  int   outstanding;
  int   replies;
  int   full_replies;
  int   range_replies;
  int   sent = 0;
  int   stall_cycles = 0;
  logic quiet = 1'b0;
  logic hold_off_req = 1'b0;

  always #1 clk = ~clk;

  block_chain_allocation_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  allocation_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .replies       (replies),
    .full_replies  (full_replies),
    .range_replies (range_replies)
  );

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold off the reply side in short bursts, once for a long stretch
  initial begin
    logic held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [WORD_W-1:0] pick_index();
    if ($urandom_range(0, 7) == 0) return rand_word();
    return WORD_W'($urandom_range(0, BLOCK_COUNT - 1));
  endfunction

  task automatic send_cmd(op_t op, logic [WORD_W-1:0] idx, logic [WORD_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, idx};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin
    logic [WORD_W-1:0] nodes [8];
    logic [WORD_W-1:0] tail;
    int                len;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(OP_READ, 16'd0, 16'h0000);
    send_cmd(OP_READ, 16'd1023, 16'hFFFF);
    send_cmd(OP_READ, 16'd1024, 16'h0000);
    send_cmd(OP_READ, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send_cmd(OP_ALLOC, 16'h0000, 16'h0000);
    send_cmd(OP_ALLOC, 16'h5A5A, 16'hA5A5);
    send_cmd(OP_SET, 16'd1, 16'd2);
    send_cmd(OP_SET, 16'd2, 16'd3);
    send_cmd(OP_FREE, 16'd1, 16'h0000);
    send_cmd(OP_FREE, 16'd0, 16'h0000);
    send_cmd(OP_FREE, 16'd1024, 16'h0000);
    send_cmd(OP_SET, 16'd5, 16'h2000);
    send_cmd(OP_FREE, 16'd5, 16'h0000);
    send_cmd(OP_SET, 16'd6, 16'd7);
    send_cmd(OP_SET, 16'd7, 16'd6);
    send_cmd(OP_FREE, 16'd6, 16'h0000);
    send_cmd(OP_SET, 16'd1023, LINK_END);
    send_cmd(OP_SET, 16'hFFFF, 16'hAAAA);
    send_cmd(OP_SET, 16'd8, 16'h5555);
    send_cmd(OP_READ, 16'd8, 16'h0000);
    send_cmd(OP_FREE, 16'd9, 16'h0000);
    send_cmd(OP_ALLOC, 16'h0000, 16'h0000);
    send_cmd(OP_READ, 16'd1023, 16'h0000);

    while (sent < 25 + RANDOM_CMDS) begin
      if (sent >= 200) hold_off_req = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) nodes[i] = WORD_W'($urandom_range(1, BLOCK_COUNT - 1));
          for (int i = 0; i < len - 1; i++) send_cmd(OP_SET, nodes[i], nodes[i + 1]);
          case ($urandom_range(0, 5))
            0:       tail = rand_word();
            1:       tail = nodes[0];
            default: tail = LINK_END;
          endcase
          send_cmd(OP_SET, nodes[len - 1], tail);
          if ($urandom_range(0, 2) == 0)
            send_cmd(OP_READ, nodes[$urandom_range(0, len - 1)], rand_word());
          if ($urandom_range(0, 4) == 0)
            send_cmd(OP_FREE, nodes[$urandom_range(0, len - 1)], rand_word());
          else
            send_cmd(OP_FREE, nodes[0], rand_word());
        end
        5, 6, 7: begin
          repeat ($urandom_range(1, 4)) send_cmd(OP_ALLOC, rand_word(), rand_word());
          if ($urandom_range(0, 1) == 0)
            send_cmd(OP_READ, WORD_W'($urandom_range(0, 63)), rand_word());
        end
        default: send_cmd(op_t'($urandom_range(0, 3)), pick_index(), rand_word());
      endcase
    end

    // run allocates back to back, then release and reuse one block
    quiet = 1'b1;
    repeat (32) send_cmd(OP_ALLOC, rand_word(), rand_word());
    send_cmd(OP_FREE, 16'd500, rand_word());
    send_cmd(OP_ALLOC, rand_word(), rand_word());
    send_cmd(OP_ALLOC, rand_word(), rand_word());
    send_cmd(OP_READ, 16'd500, rand_word());
    send_cmd(OP_READ, 16'd1023, rand_word());

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d commands (directed, random chains and noise, allocate run); %0d replies",
             sent, replies);
    $display("checked, %0d table-full and %0d out-of-range among them.",
             full_replies, range_replies);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
